// ----- sv/rglb_pkg.sv -----
// ----------------------------------------------------------------------------
// rglb_pkg
// Shared types, constants and saturation helpers for the recursive line blur.
// ----------------------------------------------------------------------------
package rglb_pkg;

  localparam int MAX_LINE_DEF = 4096;
  localparam int SAMPLE_W     = 8;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'hff;
  localparam int ORDER        = 4;
  localparam int CFG_AW       = 5;

  // Item kinds carried in tuser
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_NP0 = 3'd0;
  localparam logic [2:0] REG_NP1 = 3'd1;
  localparam logic [2:0] REG_NP2 = 3'd2;
  localparam logic [2:0] REG_NP3 = 3'd3;
  localparam logic [2:0] REG_DP1 = 3'd4;
  localparam logic [2:0] REG_DP2 = 3'd5;
  localparam logic [2:0] REG_DP3 = 3'd6;
  localparam logic [2:0] REG_DP4 = 3'd7;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
    logic                mark;
  } item_t;

  // Filter taps as seen by the engine; element 0 of d is feedback tap 1.
  typedef struct packed {
    logic                   busy;
    logic [3:0][31:0]       np;
    logic [3:0][31:0]       d;
    logic [3:0][31:0]       nm;
    logic [3:0][31:0]       bdp;
    logic [3:0][31:0]       bdm;
  } taps_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) r = 32'h7fff_ffff;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [47:0] sat48(input logic signed [63:0] v);
    logic [47:0] r;
    if (v > 64'sh0000_7fff_ffff_ffff) r = 48'h7fff_ffff_ffff;
    else if (v < -64'sh0000_8000_0000_0000) r = 48'h8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

// ----- sv/rglb_front.sv -----
// ----------------------------------------------------------------------------
// rglb_front
// Input side: takes items off the stream and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rglb_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rglb_pkg::SAMPLE_W-1:0]     in_tdata,  // [7:0] sample
  input  logic                              in_tuser,  // [0] action
  input  logic                              in_tlast,  // line_end
  output logic                              q_valid,
  output rglb_pkg::item_t                   q_item,
  input  logic                              q_pop
);
  import rglb_pkg::*;

  item_t       ent_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= '{kind: in_tuser, sample: in_tdata, mark: in_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ----- sv/rglb_cfg.sv -----
// ----------------------------------------------------------------------------
// rglb_cfg
// Register file and tap derivation: backward taps, serial divide, edge taps.
// ----------------------------------------------------------------------------
module rglb_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rglb_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output rglb_pkg::taps_t             taps
);
  import rglb_pkg::*;

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_NM   = 3'd1;
  localparam logic [2:0] C_DIVS = 3'd2;
  localparam logic [2:0] C_DIV  = 3'd3;
  localparam logic [2:0] C_DIVE = 3'd4;
  localparam logic [2:0] C_BD   = 3'd5;
  localparam int NUMW = 58;

  logic [31:0]  creg_r [8];
  logic [31:0]  nm_r [4];
  logic [31:0]  bdp_r [4];
  logic [31:0]  bdm_r [4];
  logic [2:0]   phase_r;
  logic [2:0]   idx_r;
  logic         half_r;
  logic         sel_r;
  logic         neg_r;
  logic signed [63:0] prod_r;
  logic [31:0]  a_r, b_r;
  logic [NUMW-1:0] qd_r;
  logic [34:0]  rem_r, dabs_r;
  logic [5:0]   cnt_r;

  logic         wr;
  logic signed [33:0] sum_np, sum_nm, sum_d, num;
  logic signed [34:0] den;
  logic [33:0]  num_abs;
  logic [35:0]  rem_sh;
  logic [31:0]  mop_a, mop_b, npx, qres;
  logic [NUMW-1:0] qneg;

  assign wr     = psel && penable && pwrite;
  assign prdata = creg_r[paddr[4:2]];

  function automatic logic signed [33:0] ext34(input logic [31:0] x);
    return {{2{x[31]}}, x};
  endfunction

  assign sum_np  = ext34(creg_r[REG_NP0]) + ext34(creg_r[REG_NP1])
                 + ext34(creg_r[REG_NP2]) + ext34(creg_r[REG_NP3]);
  assign sum_nm  = ext34(nm_r[0]) + ext34(nm_r[1]) + ext34(nm_r[2]) + ext34(nm_r[3]);
  assign sum_d   = ext34(creg_r[REG_DP1]) + ext34(creg_r[REG_DP2])
                 + ext34(creg_r[REG_DP3]) + ext34(creg_r[REG_DP4]);
  assign den     = 35'sh100_0000 + {sum_d[33], sum_d};
  assign num     = sel_r ? sum_nm : sum_np;
  assign num_abs = num[33] ? 34'(-num) : 34'(num);
  assign rem_sh  = {rem_r, qd_r[NUMW-1]};
  assign qneg    = -qd_r;

  // Shared multiplier operands
  always_comb begin
    mop_a = creg_r[3'd4 + {1'b0, idx_r[1:0]}];
    if (phase_r == C_NM) mop_b = creg_r[REG_NP0];
    else mop_b = idx_r[2] ? b_r : a_r;
    npx = (idx_r[1:0] == 2'd3) ? 32'd0 : creg_r[{1'b0, idx_r[1:0]} + 3'd1];
  end

  // Quotient with sign applied and clamped to 32 bits
  always_comb begin
    if (!neg_r) begin
      qres = (qd_r > NUMW'(32'h7fff_ffff)) ? 32'h7fff_ffff : qd_r[31:0];
    end else begin
      qres = (qd_r > NUMW'(33'h0_8000_0000)) ? 32'h8000_0000 : qneg[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) creg_r[i] <= '0;
    end else if (wr) begin
      creg_r[paddr[4:2]] <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(mop_a) * $signed(mop_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= C_IDLE;
      idx_r   <= '0;
      half_r  <= 1'b0;
      sel_r   <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        nm_r[i]  <= '0;
        bdp_r[i] <= '0;
        bdm_r[i] <= '0;
      end
    end else if (wr) begin
      phase_r <= C_NM;
      idx_r   <= '0;
      half_r  <= 1'b0;
    end else begin
      unique case (phase_r)
        C_IDLE: ;
        C_NM: begin
          half_r <= ~half_r;
          if (half_r) begin
            nm_r[idx_r[1:0]] <= sat32($signed({{32{npx[31]}}, npx}) - (prod_r >>> 24));
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd3) begin
              phase_r <= C_DIVS;
              sel_r   <= 1'b0;
            end
          end
        end
        C_DIVS: begin
          if (den == '0) begin
            if (sel_r) begin
              b_r     <= '0;
              phase_r <= C_BD;
              idx_r   <= '0;
              half_r  <= 1'b0;
            end else begin
              a_r   <= '0;
              sel_r <= 1'b1;
            end
          end else begin
            qd_r    <= {num_abs, 24'd0};
            rem_r   <= '0;
            dabs_r  <= den[34] ? 35'(-den) : 35'(den);
            neg_r   <= num[33] ^ den[34];
            cnt_r   <= 6'(NUMW);
            phase_r <= C_DIV;
          end
        end
        C_DIV: begin
          if (rem_sh >= {1'b0, dabs_r}) begin
            rem_r <= 35'(rem_sh - {1'b0, dabs_r});
            qd_r  <= {qd_r[NUMW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[34:0];
            qd_r  <= {qd_r[NUMW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) phase_r <= C_DIVE;
        end
        C_DIVE: begin
          if (sel_r) begin
            b_r     <= qres;
            phase_r <= C_BD;
            idx_r   <= '0;
            half_r  <= 1'b0;
          end else begin
            a_r     <= qres;
            sel_r   <= 1'b1;
            phase_r <= C_DIVS;
          end
        end
        C_BD: begin
          half_r <= ~half_r;
          if (half_r) begin
            if (idx_r[2]) bdm_r[idx_r[1:0]] <= sat32(prod_r >>> 24);
            else bdp_r[idx_r[1:0]] <= sat32(prod_r >>> 24);
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) phase_r <= C_IDLE;
          end
        end
        default: phase_r <= C_IDLE;
      endcase
    end
  end

  always_comb begin
    taps.busy = (phase_r != C_IDLE);
    for (int i = 0; i < 4; i++) begin
      taps.np[i]  = creg_r[i];
      taps.d[i]   = creg_r[4 + i];
      taps.nm[i]  = nm_r[i];
      taps.bdp[i] = bdp_r[i];
      taps.bdm[i] = bdm_r[i];
    end
  end

endmodule

// ----- sv/rglb_core.sv -----
// ----------------------------------------------------------------------------
// rglb_core
// Filter engine: forward step per sample, backward pass, result fetch.
// ----------------------------------------------------------------------------
module rglb_core #(
  parameter int MAX_LINE = rglb_pkg::MAX_LINE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  rglb_pkg::item_t               q_item,
  output logic                          q_pop,
  input  rglb_pkg::taps_t               taps,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rglb_pkg::SAMPLE_W-1:0] out_tdata,
  output logic                          out_tlast
);
  import rglb_pkg::*;

  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int CW = $clog2(MAX_LINE + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FWD   = 3'd1;
  localparam logic [2:0] S_FWR   = 3'd2;
  localparam logic [2:0] S_BWD   = 3'd3;
  localparam logic [2:0] S_BWR   = 3'd4;
  localparam logic [2:0] S_FETCH = 3'd5;
  localparam logic [3:0] OP_LAST = 4'd13;
  localparam logic signed [48:0] OUT_LIM = 49'sd4278190080;

  logic [SAMPLE_W-1:0] store_mem [MAX_LINE];
  logic [47:0]         fwd_mem [MAX_LINE];
  logic [47:0]         bwd_mem [MAX_LINE];

  logic [2:0]          state_r;
  logic [CW-1:0]       count_r, rp_r;
  logic                closed_r, mark_r;
  logic [AW-1:0]       j_r;
  logic [2:0]          t_r;
  logic [3:0]          op_r;
  logic [SAMPLE_W-1:0] cur_r, first_r, last_r, store_rd_r;
  logic [SAMPLE_W-1:0] hs_r [4];
  logic [47:0]         hv_r [4];
  logic [47:0]         fwd_rd_r, bwd_rd_r;
  logic signed [63:0]  acc_r;
  logic signed [57:0]  prod_r;
  logic                pv_r, pneg_r, psh_r;
  logic                out_valid_r, out_last_r;
  logic [SAMPLE_W-1:0] out_data_r;

  logic [3:0]          om5;
  logic [2:0]          l, lm1;
  logic [1:0]          li;
  logic                is_bwd, iss_v, iss_neg, iss_sh;
  logic [31:0]         cn, eg;
  logic signed [32:0]  mul_a;
  logic signed [24:0]  mul_b;
  logic signed [63:0]  term;
  logic [CW-1:0]       eff_count;
  logic [CW+2:0]       eff_ext;
  logic [2:0]          eff_t;
  logic [47:0]         acc_sat;
  logic signed [48:0]  sum_s;
  logic [SAMPLE_W-1:0] filt;
  logic                out_load;

  assign is_bwd = (state_r == S_BWD);
  assign om5    = op_r - 4'd5;
  assign l      = (op_r < 4'd5) ? op_r[2:0] : (3'(om5[3:1]) + 3'd1);
  assign lm1    = l - 3'd1;
  assign li     = lm1[1:0];

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    iss_v   = 1'b0;
    iss_neg = 1'b0;
    iss_sh  = 1'b0;
    cn      = is_bwd ? taps.nm[li] : ((l == 3'd4) ? 32'd0 : taps.np[l[1:0]]);
    eg      = is_bwd ? taps.bdm[li] : taps.bdp[li];
    if ((state_r == S_FWD || state_r == S_BWD) && op_r < OP_LAST) begin
      if (op_r < 4'd5) begin
        if (l <= t_r) begin
          if (l == 3'd0) begin
            mul_a = {taps.np[0][31], taps.np[0]};
            mul_b = {17'd0, cur_r};
            iss_v = !is_bwd;
          end else begin
            mul_a = {cn[31], cn};
            mul_b = {17'd0, hs_r[li]};
            iss_v = 1'b1;
          end
        end else begin
          // Term that reaches past the end of the line
          mul_a = $signed({cn[31], cn}) - $signed({eg[31], eg});
          mul_b = {17'd0, is_bwd ? last_r : first_r};
          iss_v = 1'b1;
        end
      end else if (l <= t_r) begin
        mul_a   = {taps.d[li][31], taps.d[li]};
        mul_b   = op_r[0] ? {1'b0, hv_r[li][23:0]} : {hv_r[li][47], hv_r[li][47:24]};
        iss_v   = 1'b1;
        iss_neg = 1'b1;
        iss_sh  = op_r[0];
      end
    end
  end

  assign term    = psh_r ? {{30{prod_r[57]}}, prod_r[57:24]} : {{6{prod_r[57]}}, prod_r};
  assign acc_sat = sat48(acc_r);

  assign eff_count = closed_r ? '0 : count_r;
  assign eff_ext   = {3'd0, eff_count};
  assign eff_t     = (eff_ext >= (CW+3)'(4)) ? 3'd4 : eff_ext[2:0];

  assign q_pop = (state_r == S_IDLE) && q_valid && !taps.busy;

  assign sum_s = $signed({fwd_rd_r[47], fwd_rd_r}) + $signed({bwd_rd_r[47], bwd_rd_r});
  assign filt  = sum_s[48] ? '0 : ((sum_s > OUT_LIM) ? SAMPLE_MAX : sum_s[31:24]);
  assign out_load = (state_r == S_FETCH) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Line memories
  always_ff @(posedge clk) begin
    if (q_pop && q_item.kind == ACT_PUSH && eff_count < CW'(MAX_LINE)) begin
      store_mem[eff_count[AW-1:0]] <= q_item.sample;
    end
    if (state_r == S_FWR) fwd_mem[count_r[AW-1:0]] <= acc_sat;
    if (state_r == S_BWR) bwd_mem[j_r] <= acc_sat;
    store_rd_r <= store_mem[j_r];
    fwd_rd_r   <= fwd_mem[rp_r[AW-1:0]];
    bwd_rd_r   <= bwd_mem[rp_r[AW-1:0]];
  end

  // Multiplier and accumulator
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    pneg_r <= iss_neg;
    psh_r  <= iss_sh;
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= iss_v;
    end
    if ((state_r == S_FWD || state_r == S_BWD) && op_r == 4'd0) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= pneg_r ? acc_r - term : acc_r + term;
    end
  end

  // Sample and sum history of the current pass
  always_ff @(posedge clk) begin
    if (state_r == S_FWR || state_r == S_BWR) begin
      for (int i = 3; i > 0; i--) begin
        hs_r[i] <= hs_r[i-1];
        hv_r[i] <= hv_r[i-1];
      end
      hs_r[0] <= (state_r == S_FWR) ? cur_r : store_rd_r;
      hv_r[0] <= acc_sat;
    end
    if (q_pop && q_item.kind == ACT_PUSH && eff_count < CW'(MAX_LINE)) begin
      cur_r  <= q_item.sample;
      last_r <= q_item.sample;
      mark_r <= q_item.mark;
      if (eff_count == '0) first_r <= q_item.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= filt;
      out_last_r <= ((CW+1)'(rp_r) + (CW+1)'(1)) == (CW+1)'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rp_r        <= '0;
      closed_r    <= 1'b0;
      op_r        <= '0;
      t_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r) inside
        S_IDLE: begin
          if (q_pop) begin
            if (q_item.kind == ACT_PUSH) begin
              if (closed_r) begin
                closed_r <= 1'b0;
                count_r  <= '0;
                rp_r     <= '0;
              end
              if (eff_count < CW'(MAX_LINE)) begin
                t_r     <= eff_t;
                op_r    <= '0;
                state_r <= S_FWD;
              end else if (q_item.mark) begin
                j_r     <= AW'(eff_count - CW'(1));
                t_r     <= '0;
                op_r    <= '0;
                state_r <= S_BWD;
              end
            end else if (closed_r && rp_r < count_r) begin
              state_r <= S_FETCH;
            end
          end
        end
        S_FWD, S_BWD: begin
          op_r <= op_r + 4'd1;
          if (op_r == OP_LAST) state_r <= is_bwd ? S_BWR : S_FWR;
        end
        S_FWR: begin
          count_r <= count_r + CW'(1);
          if (mark_r) begin
            j_r     <= count_r[AW-1:0];
            t_r     <= '0;
            op_r    <= '0;
            state_r <= S_BWD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_BWR: begin
          if (j_r == '0) begin
            closed_r <= 1'b1;
            rp_r     <= '0;
            state_r  <= S_IDLE;
          end else begin
            j_r     <= j_r - AW'(1);
            t_r     <= (t_r == 3'd4) ? 3'd4 : t_r + 3'd1;
            op_r    <= '0;
            state_r <= S_BWD;
          end
        end
        S_FETCH: begin
          if (out_load) begin
            rp_r    <= rp_r + CW'(1);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/recursive_gaussian_line_blur.sv -----
// ----------------------------------------------------------------------------
// recursive_gaussian_line_blur
// Fourth-order recursive Gaussian blur over one line of 8-bit mask samples.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the in_ stream: tuser low pushes the sample in tdata,
// with tlast marking the final sample of the line; tuser high asks for the
// next filtered result. Each push runs one causal filter step on the single
// shared 33x25 multiplier, which steps through the taps. A push marked tlast
// also runs the backward pass over the whole stored line. A fetch of a closed
// line that still has unread results, taken by an idle engine, yields one
// result on the out_ stream, tlast high on the last result; other fetches
// yield nothing.
// The forward taps are written through the cfg_ register port. Each write
// starts a derivation of the backward and edge taps, which includes two
// 58-step serial divides unless the divisor is zero; items wait in the queue
// until it completes.
// Reset clears the registers, derived taps and line state; the line memories
// keep their contents. If the receiver stalls, the finished result waits in
// the output register while the two-entry input queue keeps taking
// transfers, after which in_tready falls.
// ----------------------------------------------------------------------------
module recursive_gaussian_line_blur #(
  parameter int MAX_LINE = rglb_pkg::MAX_LINE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rglb_pkg::SAMPLE_W-1:0] in_tdata,   // [7:0] sample
  input  logic                          in_tuser,   // [0] action
  input  logic                          in_tlast,   // line_end
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rglb_pkg::SAMPLE_W-1:0] out_tdata,  // [7:0] filtered
  output logic                          out_tlast,  // final_one
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rglb_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import rglb_pkg::*;

  item_t q_item;
  logic  q_valid, q_pop;
  taps_t taps;

  // The register port never inserts wait states.
  assign cfg_pready = 1'b1;

  rglb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  rglb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .taps    (taps)
  );

  // The engine takes the next queued item only when idle and the taps are
  // settled, so a result waiting downstream never holds the queue itself.
  rglb_core #(.MAX_LINE(MAX_LINE)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .taps       (taps),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- sv/rglb_checker.sv -----
// ----------------------------------------------------------------------------
// rglb_checker
// Port-level checks on the blur block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rglb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rglb_pkg::SAMPLE_W-1:0] out_tdata,
  input logic                          cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  a_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("register port inserted a wait state");

endmodule

bind recursive_gaussian_line_blur rglb_checker u_rglb_checker (.*);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the recursive line blur. A scoreboard class keeps
// its own fixed-point model of both filter passes and predicts every result;
// plain tasks push lines, fetch results and program the taps over APB.
// ----------------------------------------------------------------------------
module tb;
  import rglb_pkg::*;

  localparam int      DEPTH     = MAX_LINE_DEF;
  localparam longint  Q_ONE     = 64'sd16777216;
  localparam longint  S48_MAX   = 64'sd140737488355327;
  localparam longint  S48_MIN   = -64'sd140737488355328;
  localparam longint  CYCLE_CAP = 64'd3000000;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the line memories and taps and holds the blurred
  // samples that the block still owes us, oldest first.
  // --------------------------------------------------------------------------
  typedef struct {
    logic [7:0] px;
    logic       fin;
  } blur_result_t;

  class blur_scoreboard;
    longint       coef[8];
    longint       nm_tap[4];
    longint       edge_p[4];
    longint       edge_m[4];
    longint       line_px[DEPTH];
    longint       fwd_sum[DEPTH];
    longint       bwd_sum[DEPTH];
    int           line_len;
    int           rd_ptr;
    bit           closed;
    blur_result_t owed[$];
    int           errors;

    function new();
      foreach (coef[i]) coef[i] = 0;
      foreach (nm_tap[i]) begin
        nm_tap[i] = 0;
        edge_p[i] = 0;
        edge_m[i] = 0;
      end
      line_len = 0;
      rd_ptr   = 0;
      closed   = 0;
      errors   = 0;
    endfunction

    function longint fl24(longint v);
      return v >>> 24;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint clip48(longint v);
      if (v > S48_MAX) return S48_MAX;
      if (v < S48_MIN) return S48_MIN;
      return v;
    endfunction

    // Exact floor(c * v / 2^24); splitting v keeps the product inside 64 bits.
    function longint scale(longint c, longint v);
      longint hi, lo;
      hi = fl24(v);
      lo = v - (hi <<< 24);
      return c * hi + fl24(c * lo);
    endfunction

    function longint np(int l);
      return (l >= 0 && l < ORDER) ? coef[l] : 0;
    endfunction

    function longint dp(int l);
      return (l >= 1 && l <= ORDER) ? coef[3 + l] : 0;
    endfunction

    function longint nmt(int l);
      return (l >= 1 && l <= ORDER) ? nm_tap[l - 1] : 0;
    endfunction

    function void mismatch(string what, longint exp_v, longint got_v);
      errors++;
      if (errors <= 10)
        $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, got_v);
    endfunction

    function void write_coef(int idx, logic [31:0] val);
      longint sum_np, sum_nm, sum_d, den, a, b;
      coef[idx] = longint'(signed'(val));
      sum_np = 0;
      sum_nm = 0;
      sum_d  = 0;
      a      = 0;
      b      = 0;
      for (int i = 1; i <= ORDER; i++)
        nm_tap[i - 1] = clip32(np(i) - fl24(dp(i) * np(0)));
      for (int i = 0; i < ORDER; i++) sum_np += np(i);
      for (int i = 1; i <= ORDER; i++) begin
        sum_nm += nmt(i);
        sum_d  += dp(i);
      end
      den = Q_ONE + sum_d;
      // A zero divisor leaves both edge gains at zero.
      if (den != 0) begin
        a = clip32(sum_np * Q_ONE / den);
        b = clip32(sum_nm * Q_ONE / den);
      end
      for (int i = 1; i <= ORDER; i++) begin
        edge_p[i - 1] = clip32(fl24(dp(i) * a));
        edge_m[i - 1] = clip32(fl24(dp(i) * b));
      end
    endfunction

    function void causal_step(int k);
      longint acc, first;
      int     terms;
      acc   = 0;
      first = line_px[0];
      terms = (k < ORDER) ? k : ORDER;
      for (int l = 0; l <= terms; l++) acc += np(l) * line_px[k - l];
      for (int l = 1; l <= terms; l++) acc -= scale(dp(l), fwd_sum[k - l]);
      for (int l = terms + 1; l <= ORDER; l++) acc += (np(l) - edge_p[l - 1]) * first;
      fwd_sum[k] = clip48(acc);
    endfunction

    function void anticausal_pass();
      longint acc, last;
      int     terms, j;
      last = line_px[line_len - 1];
      for (int k = 0; k < line_len; k++) begin
        acc   = 0;
        terms = (k < ORDER) ? k : ORDER;
        j     = line_len - 1 - k;
        for (int l = 1; l <= terms; l++) begin
          acc += nmt(l) * line_px[j + l];
          acc -= scale(dp(l), bwd_sum[j + l]);
        end
        for (int l = terms + 1; l <= ORDER; l++) acc += (nmt(l) - edge_m[l - 1]) * last;
        bwd_sum[j] = clip48(acc);
      end
    endfunction

    // Called for every accepted input transfer.
    function void note_item(logic kind, logic [7:0] smp, logic mark);
      longint       s;
      blur_result_t r;
      if (kind == ACT_PUSH) begin
        if (closed) begin
          line_len = 0;
          rd_ptr   = 0;
          closed   = 0;
        end
        // Samples beyond the line memory are dropped, but a mark still closes.
        if (line_len < DEPTH) begin
          line_px[line_len] = longint'(smp);
          causal_step(line_len);
          line_len++;
        end
        if (mark && line_len > 0) begin
          anticausal_pass();
          closed = 1;
          rd_ptr = 0;
        end
      end else if (closed && rd_ptr < line_len) begin
        s = fwd_sum[rd_ptr] + bwd_sum[rd_ptr];
        if (s < 0) r.px = 8'd0;
        else if (s > longint'(SAMPLE_MAX) * Q_ONE) r.px = SAMPLE_MAX;
        else r.px = 8'(s >>> 24);
        r.fin = (rd_ptr + 1 == line_len);
        owed.push_back(r);
        rd_ptr++;
      end
    endfunction

    function void check_result(logic [7:0] px, logic fin);
      blur_result_t r;
      if (owed.size() == 0) begin
        mismatch("unexpected result, filtered", -1, px);
        return;
      end
      r = owed.pop_front();
      if (px !== r.px) mismatch("filtered", r.px, px);
      if (fin !== r.fin) mismatch("final_one", r.fin, fin);
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself.
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] sample
  logic        in_tuser;    // [0] action
  logic        in_tlast;    // line_end
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [7:0] filtered
  logic        out_tlast;   // final_one
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  blur_scoreboard sb;
  longint         cycles = 0;
  bit             tx_burst;   // sender runs back to back while set
  bit             rx_burst;   // receiver never stalls while set, but for the one long hold
  int             rx_count;

  recursive_gaussian_line_blur dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side. Every result gets a fresh random stall, except in burst
  // stretches; once in the run it holds off for a long time so that the
  // result register and input queue fill and in_tready falls.
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    out_tready = 1'b0;
    rx_count   = 0;
    rx_burst   = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 9);
      if (rx_count == 40) gap = 600;
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, out_tlast);
      rx_count++;
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Input side tasks. They are entered and left at a falling edge; valid is
  // held high from one transfer to the next when no gap is drawn.
  // --------------------------------------------------------------------------
  task automatic send_item(logic kind, logic [7:0] smp, logic mark);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = kind;
    in_tdata  = smp;
    in_tlast  = mark;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, smp, mark);
    @(negedge clk);
  endtask

  // Push a whole line of random samples, the last one marked.
  task automatic push_line(int len);
    for (int i = 0; i < len; i++)
      send_item(ACT_PUSH, 8'($urandom), i == len - 1);
  endtask

  // A fetch carries random bits in the fields it does not use.
  task automatic fetch(int n);
    repeat (n) send_item(ACT_FETCH, 8'($urandom), 1'($urandom));
  endtask

  // Wait for every owed result, then for the backward pass that a marked push
  // may still be running to finish.
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (20 * sb.line_len + 300) @(negedge clk);
  endtask

  // APB write of one tap, read back to check the register.
  task automatic write_tap(int idx, logic [31:0] val);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = CFG_AW'(idx * 4);
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_coef(idx, val);
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== val) sb.mismatch("register read back", val, cfg_prdata);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Tap sets: a smooth low-pass, both extremes, a zero divisor and random.
  task automatic program_taps(int kind);
    logic [31:0] v;
    for (int r = REG_NP0; r <= REG_DP4; r++) begin
      case (kind)
        0: begin
          v = (r < REG_DP1) ? 32'($urandom_range(0, 32'h0060_0000))
                            : 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000);
        end
        1: begin
          v = 32'h7fff_ffff;
        end
        2: begin
          v = 32'h8000_0000;
        end
        3: begin
          // Feedback taps summing to minus one make the edge-gain divisor zero.
          if (r == REG_DP1) v = 32'hff00_0000;
          else if (r < REG_DP1) v = 32'($urandom_range(0, 32'h0100_0000));
          else v = 32'h0;
        end
        default: begin
          v = ($urandom_range(0, 1) == 0) ? $urandom
                                          : 32'(int'($urandom_range(0, 32'h0200_0000))
                                                - 32'h0100_0000);
        end
      endcase
      write_tap(r, v);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int sent, len, r;
    sb          = new();
    tx_burst    = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = ACT_PUSH;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: fetching with no line, a one-sample line, sample
    // extremes, fetching past the end, a tap change in mid-line and a new
    // line started while the previous one is still being read.
    program_taps(0);
    fetch(1);
    send_item(ACT_PUSH, 8'hff, 1'b1);
    fetch(2);
    send_item(ACT_PUSH, 8'h00, 1'b0);
    send_item(ACT_PUSH, 8'hff, 1'b0);
    send_item(ACT_PUSH, 8'h80, 1'b0);
    send_item(ACT_PUSH, 8'h01, 1'b1);
    fetch(5);
    push_line(1);
    send_item(ACT_PUSH, 8'h55, 1'b0);
    send_item(ACT_PUSH, 8'haa, 1'b0);
    drain();
    write_tap(REG_NP0, 32'h0080_0000);
    send_item(ACT_PUSH, 8'h7f, 1'b0);
    send_item(ACT_PUSH, 8'hfe, 1'b1);
    fetch(2);
    push_line(2);
    fetch(3);
    drain();

    // Random part: each phase takes a new tap set and runs mostly complete
    // lines read out in full, with some noise and broken lines in between.
    for (int ph = 0; ph < 8; ph++) begin
      program_taps(ph);
      sent = 0;
      while (sent < 125) begin
        r = $urandom_range(0, 9);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if (r < 7) begin
          push_line(len);
          fetch(len + $urandom_range(0, 1));
          sent += 2 * len;
        end else if (r == 7) begin
          // Read part of a line, then start the next one over it.
          push_line(len);
          fetch($urandom_range(0, len));
          sent += len;
        end else if (r == 8) begin
          fetch(2);
          sent += 2;
        end else begin
          repeat ($urandom_range(1, 4)) send_item(ACT_PUSH, 8'($urandom), 1'($urandom));
          sent += 2;
        end
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
